// ----- design/pbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Partition bounds checker package
// Field widths, status codes and parameter defaults shared by the design.
// ----------------------------------------------------------------------------
package pbc_pkg;

   localparam int NUM_PARTITIONS_DEF = 16;
   localparam int RAW_PARTITION_DEF  = 2;
   localparam int LABEL_SECTOR_DEF   = 0;

   localparam int PART_W   = 4;
   localparam int SECT_W   = 48;
   localparam int BCOUNT_W = 24;
   localparam int SB_W     = 7;
   localparam int SPC_W    = 24;
   localparam int STATUS_W = 3;
   localparam int PROD_W   = SECT_W + SB_W;   // sectors times blocks per sector
   localparam int ABS_W    = PROD_W + 1;      // absolute block number

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 96;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EOD      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LABEL_RO = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd4;

   localparam logic OP_WRITE_ENTRY = 1'b0;
   localparam logic OP_CHECK       = 1'b1;

   localparam logic CSR_SECTOR_BLOCKS = 1'b0;
   localparam logic CSR_SECTORS_PER_CYL = 1'b1;

endpackage

// ----- design/partition_bounds_checker.sv -----
// ----------------------------------------------------------------------------
// Partition bounds checker
// Checks disk transfers against a partition table held in a small memory.
// ----------------------------------------------------------------------------
// One item is processed at a time. An entry write goes straight to the
// finish state. A check takes two memory reads (the raw partition, then
// the addressed one), the multiply state S_MUL, the compare states S_EV1
// and S_EV2 and, when the request is accepted, a restoring divider that
// makes one quotient bit per cycle over the 56-bit absolute block.
// Invalid, end-of-disk and refused label write outcomes skip the divider.
// The divider sets the rate. A finished result is loaded into an output
// register, and the next item can be taken in the cycle after that while
// the result waits there. If the output register is still full and not
// being read, the finished result holds in the last state and the input
// stays blocked. Both ready outputs are low while reset is asserted.
// The partition table starts cleared after reset through one valid bit per
// entry, so no clearing pass is needed.
module partition_bounds_checker #(
   parameter int NUM_PARTITIONS = pbc_pkg::NUM_PARTITIONS_DEF,
   parameter int RAW_PARTITION  = pbc_pkg::RAW_PARTITION_DEF,
   parameter int LABEL_SECTOR   = pbc_pkg::LABEL_SECTOR_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [pbc_pkg::SPC_W-1:0]         csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: part_index[3:0], entry_offset[51:4], entry_size[99:52],
   // block_number[147:100], byte_count[171:148], is_read[172],
   // label_writable[173], zero fill above.
   input  logic [pbc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: opcode.
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: new_byte_count[23:0], residual_bytes[47:24], cylinder[95:48].
   output logic [pbc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: status.
   output logic [pbc_pkg::STATUS_W-1:0]      rsp_tuser
);
   import pbc_pkg::*;

   localparam int AW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
   localparam logic RAW_OK = (RAW_PARTITION < NUM_PARTITIONS);
   localparam logic [AW-1:0] RAW_ADDR = AW'(RAW_PARTITION);
   localparam logic [ABS_W-1:0] LABEL_ADD = ABS_W'(LABEL_SECTOR);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_RAW  = 8'b0000_0010,
      S_PART = 8'b0000_0100,
      S_MUL  = 8'b0000_1000,
      S_EV1  = 8'b0001_0000,
      S_EV2  = 8'b0010_0000,
      S_DIV  = 8'b0100_0000,
      S_FIN  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers. A write takes effect in the cycle after it.
   logic [SB_W-1:0]  sb_ff;
   logic [SPC_W-1:0] spc_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff  <= SB_W'(1);
         spc_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SECTOR_BLOCKS) begin
            sb_ff <= csr_data[SB_W-1:0];
         end else begin
            spc_ff <= csr_data;
         end
      end
   end

   // Input item unpacking.
   logic [PART_W-1:0]   in_part;
   logic [SECT_W-1:0]   in_offset, in_size, in_blk;
   logic [BCOUNT_W-1:0] in_bcount;
   assign in_part   = req_tdata[3:0];
   assign in_offset = req_tdata[51:4];
   assign in_size   = req_tdata[99:52];
   assign in_blk    = req_tdata[147:100];
   assign in_bcount = req_tdata[171:148];

   logic accept;
   assign req_tready = !reset && (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   logic [6:0]    part_ext;
   logic [AW-1:0] in_addr;
   logic          in_part_ok;
   assign part_ext   = 7'(in_part);
   assign in_addr    = part_ext[AW-1:0];
   assign in_part_ok = (part_ext < 7'(NUM_PARTITIONS));

   // Latched item fields for a check.
   logic [AW-1:0]       addr_ff;
   logic                part_ok_ff;
   logic [SECT_W-1:0]   blk_ff;
   logic [BCOUNT_W-1:0] bcount_ff;
   logic                is_read_ff, wlabel_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff    <= in_addr;
         part_ok_ff <= in_part_ok;
         blk_ff     <= in_blk;
         bcount_ff  <= in_bcount;
         is_read_ff <= req_tdata[172];
         wlabel_ff  <= req_tdata[173];
      end
   end

   // Partition table: one row of offset and size per partition, one write
   // port at input acceptance and one registered read port. Valid bits make
   // unwritten rows read as zero.
   logic [2*SECT_W-1:0]     table_mem [NUM_PARTITIONS];
   logic [NUM_PARTITIONS-1:0] valid_ff;
   logic [2*SECT_W-1:0]     rd_data_ff;
   logic                    rd_valid_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;

   assign wr_en   = accept && (req_tuser == OP_WRITE_ENTRY) && in_part_ok;
   assign rd_addr = (state_ff == S_RAW) ? RAW_ADDR : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[in_addr] <= {in_offset, in_size};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[in_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Working registers.
   logic [SECT_W-1:0]   raw_off_ff;
   logic [PROD_W-1:0]   pend_ff, offp_ff, rawp_ff;
   logic [ABS_W-1:0]    abs_ff, label_ff;
   logic [15:0]         sz_ff;
   logic [BCOUNT_W:0]   rem_ff;
   logic [ABS_W-1:0]    quo_ff;
   logic [5:0]          cnt_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [BCOUNT_W-1:0] res_ncount_ff, res_resid_ff;

   // Next-value signals.
   logic [SECT_W-1:0]   raw_off_in;
   logic [PROD_W-1:0]   pend_in, offp_in, rawp_in;
   logic [ABS_W-1:0]    abs_in, label_in;
   logic [15:0]         sz_in;
   logic [BCOUNT_W:0]   rem_in;
   logic [ABS_W-1:0]    quo_in;
   logic [5:0]          cnt_in;
   logic [STATUS_W-1:0] res_status_in;
   logic [BCOUNT_W-1:0] res_ncount_in, res_resid_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BCOUNT_W-1:0] rsp_ncount_ff, rsp_ncount_in, rsp_resid_ff, rsp_resid_in;
   logic [SECT_W-1:0]   rsp_cyl_ff, rsp_cyl_in;

   // Shared combinational terms.
   logic [SECT_W-1:0]   part_off, part_size;
   logic [15:0]         sz0;
   logic [ABS_W-1:0]    blk_ext, sum_req, pend_ext, pend_minus;
   logic [ABS_W:0]      abs_end;
   logic [BCOUNT_W:0]   trial;
   logic                qbit;
   logic                slot_free;

   assign part_off  = (part_ok_ff && rd_valid_ff) ? rd_data_ff[2*SECT_W-1:SECT_W] : '0;
   assign part_size = (part_ok_ff && rd_valid_ff) ? rd_data_ff[SECT_W-1:0] : '0;
   assign sz0       = 16'((BCOUNT_W+1)'(bcount_ff) + (BCOUNT_W+1)'(511) >> 9);
   assign blk_ext   = ABS_W'(blk_ff);
   assign sum_req   = blk_ext + ABS_W'(sz0);
   assign pend_ext  = ABS_W'(pend_ff);
   assign pend_minus = pend_ext - blk_ext;
   assign abs_end   = (ABS_W+1)'(abs_ff) + (ABS_W+1)'(sz_ff);
   assign trial     = {rem_ff[BCOUNT_W-1:0], quo_ff[ABS_W-1]};
   assign qbit      = (trial >= (BCOUNT_W+1)'(spc_ff));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      raw_off_in    = raw_off_ff;
      pend_in       = pend_ff;
      offp_in       = offp_ff;
      rawp_in       = rawp_ff;
      abs_in        = abs_ff;
      label_in      = label_ff;
      sz_in         = sz_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_ncount_in = res_ncount_ff;
      res_resid_in  = res_resid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_ncount_in = rsp_ncount_ff;
      rsp_resid_in  = rsp_resid_ff;
      rsp_cyl_in    = rsp_cyl_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               quo_in        = '0;
               res_ncount_in = '0;
               res_resid_in  = '0;
               if (req_tuser == OP_WRITE_ENTRY) begin
                  res_status_in = ST_ENTRY;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_RAW;
               end
            end
         end
         S_RAW: begin
            state_in = S_PART;
         end
         S_PART: begin
            // The raw partition row is on the read port now.
            raw_off_in = (RAW_OK && rd_valid_ff) ? rd_data_ff[2*SECT_W-1:SECT_W] : '0;
            state_in   = S_MUL;
         end
         S_MUL: begin
            pend_in  = PROD_W'(part_size) * PROD_W'(sb_ff);
            offp_in  = PROD_W'(part_off) * PROD_W'(sb_ff);
            rawp_in  = PROD_W'(raw_off_ff) * PROD_W'(sb_ff);
            state_in = S_EV1;
         end
         S_EV1: begin
            res_ncount_in = bcount_ff;
            res_resid_in  = '0;
            sz_in         = sz0;
            abs_in        = blk_ext + ABS_W'(offp_ff);
            label_in      = ABS_W'(rawp_ff) + LABEL_ADD;
            state_in      = S_EV2;
            if (spc_ff == '0) begin
               res_status_in = ST_INVALID;
               state_in      = S_FIN;
            end else if (sum_req > pend_ext) begin
               priority if (blk_ext == pend_ext) begin
                  res_status_in = ST_EOD;
                  res_resid_in  = bcount_ff;
                  state_in      = S_FIN;
               end else if (blk_ext > pend_ext) begin
                  res_status_in = ST_INVALID;
                  state_in      = S_FIN;
               end else begin
                  // Partial overlap: cut to whole blocks up to the end.
                  sz_in         = pend_minus[15:0];
                  res_ncount_in = {pend_minus[14:0], 9'b0};
               end
            end
         end
         S_EV2: begin
            if (abs_ff <= label_ff && abs_end > (ABS_W+1)'(label_ff)
                && !is_read_ff && !wlabel_ff) begin
               res_status_in = ST_LABEL_RO;
               state_in      = S_FIN;
            end else begin
               res_status_in = ST_OK;
               rem_in        = '0;
               quo_in        = abs_ff;
               cnt_in        = 6'(ABS_W - 1);
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = qbit ? (trial - (BCOUNT_W+1)'(spc_ff)) : trial;
            quo_in = {quo_ff[ABS_W-2:0], qbit};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ncount_in = res_ncount_ff;
               rsp_resid_in  = res_resid_ff;
               rsp_cyl_in    = quo_ff[SECT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_off_ff    <= raw_off_in;
      pend_ff       <= pend_in;
      offp_ff       <= offp_in;
      rawp_ff       <= rawp_in;
      abs_ff        <= abs_in;
      label_ff      <= label_in;
      sz_ff         <= sz_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_ncount_ff <= res_ncount_in;
      res_resid_ff  <= res_resid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ncount_ff <= rsp_ncount_in;
      rsp_resid_ff  <= rsp_resid_in;
      rsp_cyl_ff    <= rsp_cyl_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_cyl_ff, rsp_resid_ff, rsp_ncount_ff};

   // The divider counts down one step per cycle.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff != '0) |=> (cnt_ff == $past(cnt_ff) - 6'd1))
      else $error("divider step count skipped");

   // An accepted in-range entry write marks its row valid.
   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(in_addr)])
      else $error("entry write did not set valid bit");

   // Only end of disk carries data in the residual field.
   a_resid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_EOD) |-> (rsp_resid_ff == '0))
      else $error("residual bytes on a result that must have none");

endmodule

// ----- test/pbc_checker.sv -----
// ----------------------------------------------------------------------------
// Partition bounds checker scoreboard
// Watches the request, response and register channels, predicts each response
// from its own copy of the partition table and geometry, and compares.
// ----------------------------------------------------------------------------
module pbc_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic                           csr_index,
   input  logic [pbc_pkg::SPC_W-1:0]      csr_data,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [pbc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [pbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [pbc_pkg::STATUS_W-1:0]   rsp_tuser,
   output int                             failures,
   output int                             pending
);
   import pbc_pkg::*;

   localparam int LABEL_PART = RAW_PARTITION_DEF;
   localparam int LABEL_SEC  = LABEL_SECTOR_DEF;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [23:0]         new_count;
      logic [23:0]         residual;
      logic [47:0]         cylinder;
   } outcome_type;

   logic [47:0] part_offset [NUM_PARTITIONS_DEF];
   logic [47:0] part_size [NUM_PARTITIONS_DEF];
   logic [6:0]  blocks_per_sector;
   logic [23:0] sectors_per_cyl;
   outcome_type expected_q [$];

   assign pending = expected_q.size();

   function automatic outcome_type check_transfer(logic [3:0] part, logic [47:0] blk,
                                                  logic [23:0] count, logic rd,
                                                  logic wlabel);
      outcome_type r;
      logic [63:0] blocks;
      logic [63:0] part_end;
      logic [63:0] label_blk;
      logic [63:0] abs_blk;
      r = '0;
      blocks = (64'(count) + 64'd511) >> 9;
      r.new_count = count;
      if (sectors_per_cyl == 0) begin
         r.status = ST_INVALID;
         return r;
      end
      part_end = 64'(part_size[part]) * 64'(blocks_per_sector);
      if (64'(blk) + blocks > part_end) begin
         if (64'(blk) == part_end) begin
            r.status = ST_EOD;
            r.residual = count;
            return r;
         end
         if (64'(blk) > part_end) begin
            r.status = ST_INVALID;
            return r;
         end
         blocks = part_end - 64'(blk);
         r.new_count = 24'(blocks << 9);
      end
      label_blk = 64'(part_offset[LABEL_PART]) * 64'(blocks_per_sector) + 64'(LABEL_SEC);
      abs_blk = 64'(blk) + 64'(part_offset[part]) * 64'(blocks_per_sector);
      if (abs_blk <= label_blk && abs_blk + blocks > label_blk && !rd && !wlabel) begin
         r.status = ST_LABEL_RO;
         return r;
      end
      r.status = ST_OK;
      r.cylinder = 48'(abs_blk / 64'(sectors_per_cyl));
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         for (int i = 0; i < NUM_PARTITIONS_DEF; i++) begin
            part_offset[i] = '0;
            part_size[i] = '0;
         end
         blocks_per_sector = 7'd1;
         sectors_per_cyl = '0;
         expected_q.delete();
         failures = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.new_count = rsp_tdata[23:0];
            got.residual = rsp_tdata[47:24];
            got.cylinder = rsp_tdata[95:48];
            if (expected_q.size() == 0) begin
               failures++;
               $display("%0t: response with none expected: status %0d", $time, got.status);
            end else begin
               want = expected_q.pop_front();
               if (got.status != want.status) begin
                  failures++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
               end
               if (got.new_count != want.new_count) begin
                  failures++;
                  $display("%0t: new_byte_count expected %0h actual %0h",
                           $time, want.new_count, got.new_count);
               end
               if (got.residual != want.residual) begin
                  failures++;
                  $display("%0t: residual_bytes expected %0h actual %0h",
                           $time, want.residual, got.residual);
               end
               if (got.cylinder != want.cylinder) begin
                  failures++;
                  $display("%0t: cylinder expected %0h actual %0h",
                           $time, want.cylinder, got.cylinder);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SECTOR_BLOCKS)
               blocks_per_sector = csr_data[6:0];
            else
               sectors_per_cyl = csr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE_ENTRY) begin
               part_offset[req_tdata[3:0]] = req_tdata[51:4];
               part_size[req_tdata[3:0]] = req_tdata[99:52];
               want = '0;
               want.status = ST_ENTRY;
            end else begin
               want = check_transfer(req_tdata[3:0], req_tdata[147:100], req_tdata[171:148],
                                     req_tdata[172], req_tdata[173]);
            end
            expected_q.push_back(want);
         end
      end
   end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Partition bounds checker testbench
// Drives directed and random table writes and transfer checks under several
// geometry settings and idling patterns; the scoreboard does the checking.
// ----------------------------------------------------------------------------
module testbench;
   import pbc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 325;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic                    csr_index = CSR_SECTOR_BLOCKS;
   logic [SPC_W-1:0]        csr_data = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // tdata: part_index, entry_offset, entry_size, block_number, byte_count,
   // is_read, label_writable, zero fill.
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   // tuser: opcode.
   logic                    req_tuser = OP_WRITE_ENTRY;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // tdata: new_byte_count, residual_bytes, cylinder.
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   // tuser: status.
   logic [STATUS_W-1:0]     rsp_tuser;

   int failures;
   int pending;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;

   // Shadow of what the stimulus has written, used only to aim block numbers
   // at interesting places near the partition ends.
   logic [47:0] aim_offset [16];
   logic [47:0] aim_size [16];
   logic [6:0]  aim_sb = 7'd1;

   always #5 clock = ~clock;

   partition_bounds_checker u_top (.*);

   pbc_checker u_checker (.*);

   // The receiver stalls at random with the rate of the current phase.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // The run is stuck if no transfer of any kind happens for a long time.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Registers are only written once every response has come back. The
   // request side is idled first, and the outstanding count is looked at after
   // the next edge so that the last request transfer is already counted.
   task automatic write_register(logic idx, logic [SPC_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SECTOR_BLOCKS) aim_sb = value[6:0];
   endtask

   task automatic set_geometry(logic [6:0] sb, logic [23:0] spc);
      write_register(CSR_SECTOR_BLOCKS, 24'(sb));
      write_register(CSR_SECTORS_PER_CYL, spc);
   endtask

   // One request transfer; valid stays up between back-to-back items.
   task automatic send_request(logic op, logic [3:0] part, logic [47:0] off, logic [47:0] size,
                               logic [47:0] blk, logic [23:0] count, logic rd, logic wlabel);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, wlabel, rd, count, blk, size, off, part};
      do @(posedge clock); while (!req_tready);
      if (op == OP_WRITE_ENTRY) begin
         aim_offset[part] = off;
         aim_size[part] = size;
      end
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   // Random items: mostly small partitions near the raw partition, so that
   // block numbers land near the partition ends and over the label.
   task automatic random_item();
      logic [3:0]  part;
      logic [47:0] off;
      logic [47:0] size;
      logic [47:0] blk;
      logic [23:0] count;
      logic [63:0] part_end;
      int          pick;
      part = 4'($urandom_range(15));
      if ($urandom_range(99) < 15) begin
         pick = $urandom_range(3);
         off = (pick == 0) ? rand48() : (pick == 1) ? 48'($urandom) : 48'($urandom_range(3));
         pick = $urandom_range(3);
         size = (pick == 0) ? rand48() : (pick == 1) ? 48'($urandom) : 48'($urandom_range(64));
         send_request(OP_WRITE_ENTRY, part, off, size, rand48(), 24'($urandom),
                      1'($urandom), 1'($urandom));
      end else begin
         part_end = 64'(aim_size[part]) * 64'(aim_sb);
         pick = $urandom_range(99);
         if (pick < 40)
            blk = 48'((part_end > 40) ? part_end - $urandom_range(40) : $urandom_range(40));
         else if (pick < 60)
            blk = 48'(part_end);
         else if (pick < 75)
            blk = 48'(part_end + $urandom_range(1, 8));
         else if (pick < 90)
            blk = rand48();
         else
            blk = '0;
         pick = $urandom_range(99);
         if (pick < 40)
            count = 24'($urandom_range(40 * 512));
         else if (pick < 60) begin
            case ($urandom_range(5))
               0: count = 24'd0;
               1: count = 24'd1;
               2: count = 24'd511;
               3: count = 24'd512;
               4: count = 24'd513;
               default: count = 24'hFF_FFFF;
            endcase
         end else
            count = 24'($urandom);
         send_request(OP_CHECK, part, rand48(), rand48(), blk, count,
                      $urandom_range(2) == 0, $urandom_range(2) == 0);
      end
   endtask

   initial begin
      logic [6:0]  sb_list [6];
      logic [23:0] spc_list [6];
      sb_list = '{7'd1, 7'd64, 7'd8, 7'd0, 7'd127, 7'd2};
      spc_list = '{24'd63, 24'hFF_FFFF, 24'd1, 24'd1000, 24'd5, 24'd255};
      for (int i = 0; i < 16; i++) begin
         aim_offset[i] = '0;
         aim_size[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Under the reset geometry every check is invalid.
      send_request(OP_CHECK, 4'd0, '0, '0, '0, 24'd512, 1'b0, 1'b0);
      send_request(OP_CHECK, 4'd15, '0, '0, 48'd5, 24'hFF_FFFF, 1'b1, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         // Idling patterns: sender light and receiver heavy, then swapped,
         // then no idling at all.
         send_idle_pct = (ph < 2) ? 25 : (ph < 4) ? 78 : 0;
         recv_stall_pct = (ph < 2) ? 78 : (ph < 4) ? 25 : 0;
         set_geometry(sb_list[ph], spc_list[ph]);
         if (ph == 0) begin
            // Label sits at block 10; partition 2 spans blocks 10 to 109.
            send_request(OP_WRITE_ENTRY, 4'd2, 48'd10, 48'd100, '0, '0, 1'b0, 1'b0);
            send_request(OP_WRITE_ENTRY, 4'd5, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                         48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b1);
            send_request(OP_WRITE_ENTRY, 4'd0, '0, '0, '0, '0, 1'b0, 1'b0);
            // Write over the label: refused, then permitted, then a read.
            send_request(OP_CHECK, 4'd2, '0, '0, '0, 24'd512, 1'b0, 1'b0);
            send_request(OP_CHECK, 4'd2, '0, '0, '0, 24'd512, 1'b0, 1'b1);
            send_request(OP_CHECK, 4'd2, '0, '0, '0, 24'd512, 1'b1, 1'b0);
            // Exactly at the end, empty at the end, past the end, partial.
            send_request(OP_CHECK, 4'd2, '0, '0, 48'd100, 24'd1, 1'b1, 1'b0);
            send_request(OP_CHECK, 4'd2, '0, '0, 48'd100, 24'd0, 1'b0, 1'b0);
            send_request(OP_CHECK, 4'd2, '0, '0, 48'd101, 24'd1, 1'b1, 1'b0);
            send_request(OP_CHECK, 4'd2, '0, '0, 48'd98, 24'd4096, 1'b0, 1'b0);
            // Largest partition: at its end, and a huge cylinder.
            send_request(OP_CHECK, 4'd5, '0, '0, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 1'b1, 1'b0);
            send_request(OP_CHECK, 4'd5, '0, '0, '0, 24'hFF_FFFF, 1'b1, 1'b0);
            send_request(OP_CHECK, 4'd0, '0, '0, '0, 24'd0, 1'b0, 1'b0);
            send_request(OP_CHECK, 4'd15, '0, '0, '0, 24'd1, 1'b0, 1'b0);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            random_item();
         req_tvalid <= 1'b0;
      end

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
